// ===== rtl/mwto_pkg.sv =====
// ----------------------------------------------------------------------------
// mwto_pkg
// Shared types, widths and constants of the multiwave tone oscillator.
// ----------------------------------------------------------------------------
`default_nettype none

package mwto_pkg;

   localparam int unsigned LEVEL_W    = 8;
   localparam int unsigned DUTY_W     = 5;
   localparam int unsigned COUNT_W    = 16;
   localparam int unsigned MODE_W     = 3;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 16;
   localparam int unsigned LFSR_W     = 16;
   localparam int unsigned PWM_SLOTS  = 16;
   localparam int unsigned DUTY_CAP   = 31;
   localparam int unsigned LEVELS     = 1 << LEVEL_W;

   localparam logic [LFSR_W-1:0]  LFSR_SEED    = 16'hACE1;
   localparam logic [LFSR_W-1:0]  LFSR_TAPS    = 16'hB400;
   localparam logic [LEVEL_W-1:0] VOLUME_RESET = 8'hFF;

   typedef enum logic [MODE_W-1:0] {
      WAVE_OFF      = 3'd0,
      WAVE_SQUARE   = 3'd1,
      WAVE_SAW      = 3'd2,
      WAVE_TRIANGLE = 3'd3,
      WAVE_NOISE    = 3'd4
   } wave_mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WAVE_MODE   = 2'd0,
      CSR_HALF_PERIOD = 2'd1,
      CSR_STEP_PERIOD = 2'd2,
      CSR_VOLUME      = 2'd3
   } csr_index_type;

   // PWM high slots for one level, worked out at elaboration
   function automatic logic [DUTY_W-1:0] duty_calc(input int unsigned lvl);
      int unsigned q;
      q = (lvl + 1) / PWM_SLOTS;
      if (q > PWM_SLOTS) q = PWM_SLOTS;
      if (q > DUTY_CAP) q = DUTY_CAP;
      return DUTY_W'(q);
   endfunction

endpackage

`default_nettype wire

// ===== rtl/mwto_req_if.sv =====
// ----------------------------------------------------------------------------
// mwto_req_if
// Tick request channel: valid, ready and the advance flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface mwto_req_if;
   logic valid;
   logic ready;
   logic advance;

   modport source (output valid, output advance, input ready);
   modport sink   (input valid, input advance, output ready);
endinterface

`default_nettype wire

// ===== rtl/mwto_rsp_if.sv =====
// ----------------------------------------------------------------------------
// mwto_rsp_if
// Result channel: valid, ready, the oscillator level and its PWM duty.
// ----------------------------------------------------------------------------
`default_nettype none

interface mwto_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [mwto_pkg::LEVEL_W-1:0]     level;
   logic [mwto_pkg::DUTY_W-1:0]      duty_slots;

   modport source (output valid, output level, output duty_slots, input ready);
   modport sink   (input valid, input level, input duty_slots, output ready);
endinterface

`default_nettype wire

// ===== rtl/mwto_duty.sv =====
// ----------------------------------------------------------------------------
// mwto_duty
// Maps a level to its count of PWM high slots through a constant table.
// ----------------------------------------------------------------------------
`default_nettype none

module mwto_duty (
   input  wire logic [mwto_pkg::LEVEL_W-1:0] level,
   output logic      [mwto_pkg::DUTY_W-1:0]  duty_slots
);

   logic [mwto_pkg::DUTY_W-1:0] duty_lut [mwto_pkg::LEVELS];

   for (genvar i = 0; i < mwto_pkg::LEVELS; i++) begin : g_lut
      assign duty_lut[i] = mwto_pkg::duty_calc(i);
   end

   assign duty_slots = duty_lut[level];

endmodule

`default_nettype wire

// ===== rtl/multiwave_tone_oscillator_unit.sv =====
// ----------------------------------------------------------------------------
// multiwave_tone_oscillator_unit
// Square, saw, triangle and noise tone oscillator, one sample tick per item.
//
// Usage:
//   req carries one tick; advance high steps the oscillator, advance low only
//   reports the current level. rsp returns the level and its PWM duty.
//   csr_we/csr_index/csr_wdata write wave_mode, half_period, step_period and
//   volume; write them only while no tick is in flight.
//   The result of a tick is registered into the level register at the edge
//   that accepts it. Throughput is one tick per cycle while rsp is not
//   stalled; the state update and the noise multiply sit in one
//   combinational pass into the state and output registers.
//   The level register doubles as the output register. When rsp is stalled
//   the result holds and req.ready drops until the result is taken; a tick
//   is taken in the same cycle as the waiting result.
//   Synchronous reset clears counters, level and ramp direction, seeds the
//   LFSR with 0xACE1, sets volume to 255 and the other registers to zero,
//   and empties the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module multiwave_tone_oscillator_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   mwto_req_if.sink                                 req,
   mwto_rsp_if.source                               rsp,
   input  wire logic                                csr_we,
   input  wire logic [mwto_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [mwto_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int unsigned LW = mwto_pkg::LEVEL_W;
   localparam int unsigned CW = mwto_pkg::COUNT_W;
   localparam int unsigned RW = mwto_pkg::LFSR_W;

   logic [mwto_pkg::MODE_W-1:0] wave_mode_ff;
   logic [CW-1:0]               half_period_ff;
   logic [CW-1:0]               step_period_ff;
   logic [LW-1:0]               volume_ff;

   logic [CW-1:0] period_count_ff, period_count_in;
   logic [CW-1:0] step_count_ff,   step_count_in;
   logic [LW-1:0] wave_level_ff,   wave_level_in;
   logic          ramp_down_ff,    ramp_down_in;
   logic [RW-1:0] noise_lfsr_ff,   noise_lfsr_in;
   logic          rsp_valid_ff;

   logic               accept;
   logic [CW-1:0]      period_inc;
   logic [CW-1:0]      step_inc;
   logic               period_hit;
   logic               step_hit;
   logic [RW-1:0]      lfsr_next;
   logic [RW+LW-1:0]   noise_product;
   logic [LW-1:0]      saw_base;

   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         wave_mode_ff   <= mwto_pkg::WAVE_OFF;
         half_period_ff <= '0;
         step_period_ff <= '0;
         volume_ff      <= mwto_pkg::VOLUME_RESET;
      end else if (csr_we) begin
         unique case (mwto_pkg::csr_index_type'(csr_index))
            mwto_pkg::CSR_WAVE_MODE:   wave_mode_ff   <= csr_wdata[mwto_pkg::MODE_W-1:0];
            mwto_pkg::CSR_HALF_PERIOD: half_period_ff <= csr_wdata[CW-1:0];
            mwto_pkg::CSR_STEP_PERIOD: step_period_ff <= csr_wdata[CW-1:0];
            mwto_pkg::CSR_VOLUME:      volume_ff      <= csr_wdata[LW-1:0];
            default: ;
         endcase
      end
   end

   // next oscillator state
   assign period_inc    = CW'(period_count_ff + 1'b1);
   assign step_inc      = CW'(step_count_ff + 1'b1);
   assign period_hit    = period_inc > half_period_ff;
   assign step_hit      = step_inc > step_period_ff;
   assign lfsr_next     = {1'b0, noise_lfsr_ff[RW-1:1]}
                          ^ (noise_lfsr_ff[0] ? mwto_pkg::LFSR_TAPS : '0);
   assign noise_product = {{LW{1'b0}}, lfsr_next} * {{RW{1'b0}}, volume_ff};
   assign saw_base      = period_hit ? '0 : wave_level_ff;

   always_comb begin
      period_count_in = period_count_ff;
      step_count_in   = step_count_ff;
      wave_level_in   = wave_level_ff;
      ramp_down_in    = ramp_down_ff;
      noise_lfsr_in   = noise_lfsr_ff;
      if (req.advance) begin
         period_count_in = period_inc;
         step_count_in   = step_inc;
         case (mwto_pkg::wave_mode_type'(wave_mode_ff))
            mwto_pkg::WAVE_SQUARE: begin
               if (period_hit) begin
                  period_count_in = '0;
                  wave_level_in   = (wave_level_ff != '0) ? '0 : volume_ff;
               end
            end
            mwto_pkg::WAVE_SAW: begin
               if (period_hit) period_count_in = '0;
               wave_level_in = saw_base;
               if (step_hit) begin
                  step_count_in = '0;
                  wave_level_in = LW'(saw_base + 1'b1);
               end
            end
            mwto_pkg::WAVE_TRIANGLE: begin
               if (step_hit) begin
                  step_count_in = '0;
                  wave_level_in = ramp_down_ff ? LW'(wave_level_ff - 1'b1)
                                               : LW'(wave_level_ff + 1'b1);
               end
               if (period_hit) begin
                  period_count_in = '0;
                  ramp_down_in    = !ramp_down_ff;
               end
            end
            mwto_pkg::WAVE_NOISE: begin
               if (period_hit) begin
                  period_count_in = '0;
                  noise_lfsr_in   = lfsr_next;
                  wave_level_in   = noise_product[RW+LW-1:RW];
               end
            end
            default: wave_level_in = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_count_ff <= '0;
         step_count_ff   <= '0;
         wave_level_ff   <= '0;
         ramp_down_ff    <= 1'b0;
         noise_lfsr_ff   <= mwto_pkg::LFSR_SEED;
      end else if (accept) begin
         period_count_ff <= period_count_in;
         step_count_ff   <= step_count_in;
         wave_level_ff   <= wave_level_in;
         ramp_down_ff    <= ramp_down_in;
         noise_lfsr_ff   <= noise_lfsr_in;
      end
   end

   // output stage
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.level = wave_level_ff;

   mwto_duty u_duty (
      .level      (wave_level_ff),
      .duty_slots (rsp.duty_slots)
   );

   // checks
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp.valid)
      else $error("no result after an accepted tick");

   a_hold_no_advance: assert property (@(posedge clock) disable iff (reset)
      accept && !req.advance |=> $stable(wave_level_ff) && $stable(period_count_ff))
      else $error("state moved on a non-advancing tick");

   a_off_silent: assert property (@(posedge clock) disable iff (reset)
      accept && req.advance && wave_mode_ff == mwto_pkg::WAVE_OFF
      |=> wave_level_ff == '0)
      else $error("level not zero in off mode");

   a_lfsr_nonzero: assert property (@(posedge clock) disable iff (reset)
      noise_lfsr_ff != '0)
      else $error("noise LFSR locked at zero");

endmodule

`default_nettype wire

// ===== tb/sv/multiwave_tone_oscillator_unit_tb.sv =====
// ----------------------------------------------------------------------------
// multiwave_tone_oscillator_unit_tb
// Self-checking bench for the square/saw/triangle/noise tone oscillator.
// Ticks are fed from a queue by a clocked driver. Each accepted tick runs
// through a cycle-level oscillator predictor, and the monitor checks level
// and PWM duty of each returned transfer in order. The run steps through
// directed settings, a long run with restarts disabled and randomised
// configuration phases, under several sender and receiver idling patterns.
// ----------------------------------------------------------------------------
`default_nettype none

module multiwave_tone_oscillator_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int unsigned MAX_REPORTS  = 10;
   localparam int unsigned WRAP_TICKS   = 100;
   localparam int unsigned RAND_PHASES  = 16;
   localparam int unsigned PHASE_TICKS  = 94;
   localparam logic [mwto_pkg::MODE_W-1:0] WAVE_SPARE_LO = 3'd5;
   localparam logic [mwto_pkg::MODE_W-1:0] WAVE_SPARE_HI = 3'd7;

   typedef struct packed {
      logic [mwto_pkg::LEVEL_W-1:0] level;
      logic [mwto_pkg::DUTY_W-1:0]  duty_slots;
      logic [31:0]                  stamp;
   } tone_type;

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            csr_we;
   logic [mwto_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [mwto_pkg::CSR_DATA_W-1:0] csr_wdata;

   mwto_req_if tick_ch ();
   mwto_rsp_if tone_ch ();

   multiwave_tone_oscillator_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req       (tick_ch),
      .rsp       (tone_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // oscillator configuration and state as predicted
   logic [mwto_pkg::MODE_W-1:0]  cfg_mode;
   logic [mwto_pkg::COUNT_W-1:0] cfg_half;
   logic [mwto_pkg::COUNT_W-1:0] cfg_step;
   logic [mwto_pkg::LEVEL_W-1:0] cfg_volume;
   logic [mwto_pkg::COUNT_W-1:0] osc_period;
   logic [mwto_pkg::COUNT_W-1:0] osc_step;
   logic [mwto_pkg::LEVEL_W-1:0] osc_level;
   logic                         osc_falling;
   logic [mwto_pkg::LFSR_W-1:0]  osc_lfsr;

   logic      pending_ticks[$];
   tone_type  expected_tones[$];
   int unsigned cycle_count = 0;
   int unsigned error_count = 0;
   int unsigned send_idle_pct;
   int unsigned recv_stall_pct;

   function automatic tone_type tone_after_tick(input logic adv);
      tone_type    r;
      logic        period_hit;
      logic        step_hit;
      logic [31:0] prod;
      int unsigned q;
      if (adv) begin
         osc_period = osc_period + 1'b1;
         osc_step   = osc_step + 1'b1;
         period_hit = osc_period > cfg_half;
         step_hit   = osc_step > cfg_step;
         case (cfg_mode)
            mwto_pkg::WAVE_SQUARE: begin
               if (period_hit) begin
                  osc_period = '0;
                  osc_level  = (osc_level != '0) ? '0 : cfg_volume;
               end
            end
            mwto_pkg::WAVE_SAW: begin
               if (period_hit) begin
                  osc_period = '0;
                  osc_level  = '0;
               end
               if (step_hit) begin
                  osc_step  = '0;
                  osc_level = osc_level + 1'b1;
               end
            end
            mwto_pkg::WAVE_TRIANGLE: begin
               if (step_hit) begin
                  osc_step  = '0;
                  osc_level = osc_falling ? osc_level - 1'b1 : osc_level + 1'b1;
               end
               if (period_hit) begin
                  osc_period  = '0;
                  osc_falling = ~osc_falling;
               end
            end
            mwto_pkg::WAVE_NOISE: begin
               if (period_hit) begin
                  osc_period = '0;
                  osc_lfsr   = {1'b0, osc_lfsr[mwto_pkg::LFSR_W-1:1]}
                               ^ (osc_lfsr[0] ? mwto_pkg::LFSR_TAPS : '0);
                  prod       = osc_lfsr * cfg_volume;
                  osc_level  = prod[mwto_pkg::LFSR_W +: mwto_pkg::LEVEL_W];
               end
            end
            default: osc_level = '0;
         endcase
      end
      q = (int'(osc_level) + 1) / mwto_pkg::PWM_SLOTS;
      if (q > mwto_pkg::PWM_SLOTS) q = mwto_pkg::PWM_SLOTS;
      if (q > mwto_pkg::DUTY_CAP) q = mwto_pkg::DUTY_CAP;
      r.level      = osc_level;
      r.duty_slots = q[mwto_pkg::DUTY_W-1:0];
      r.stamp      = cycle_count;
      return r;
   endfunction

   task automatic note_error(input string what, input int unsigned want,
                             input int unsigned got);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("mismatch at cycle %0d: %s expected %0d got %0d", cycle_count, what, want, got);
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin : tick_driver
      if (reset) begin
         tick_ch.valid <= 1'b0;
      end else begin
         if (tick_ch.valid && tick_ch.ready)
            expected_tones.push_back(tone_after_tick(tick_ch.advance));
         if (!tick_ch.valid || tick_ch.ready) begin
            if (pending_ticks.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               tick_ch.valid   <= 1'b1;
               tick_ch.advance <= pending_ticks.pop_front();
            end else begin
               tick_ch.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : tone_monitor
      tone_type want;
      if (!reset && tone_ch.valid && tone_ch.ready) begin
         if (expected_tones.size() == 0 || expected_tones[0].stamp >= cycle_count) begin
            note_error("unexpected transfer, level", 0, tone_ch.level);
         end else begin
            want = expected_tones.pop_front();
            if (tone_ch.level !== want.level)
               note_error("level", want.level, tone_ch.level);
            if (tone_ch.duty_slots !== want.duty_slots)
               note_error("duty_slots", want.duty_slots, tone_ch.duty_slots);
         end
      end
      tone_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   task automatic write_reg(input mwto_pkg::csr_index_type idx,
                            input logic [mwto_pkg::CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         mwto_pkg::CSR_WAVE_MODE:   cfg_mode   = data[mwto_pkg::MODE_W-1:0];
         mwto_pkg::CSR_HALF_PERIOD: cfg_half   = data;
         mwto_pkg::CSR_STEP_PERIOD: cfg_step   = data;
         mwto_pkg::CSR_VOLUME:      cfg_volume = data[mwto_pkg::LEVEL_W-1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic configure(input logic [mwto_pkg::MODE_W-1:0]  mode,
                            input logic [mwto_pkg::COUNT_W-1:0] half,
                            input logic [mwto_pkg::COUNT_W-1:0] step,
                            input logic [mwto_pkg::LEVEL_W-1:0] vol);
      logic [mwto_pkg::CSR_DATA_W-1:0] junk;
      junk = mwto_pkg::CSR_DATA_W'($urandom_range(0, 65535));
      write_reg(mwto_pkg::CSR_WAVE_MODE,
                {junk[mwto_pkg::CSR_DATA_W-1:mwto_pkg::MODE_W], mode});
      write_reg(mwto_pkg::CSR_HALF_PERIOD, half);
      write_reg(mwto_pkg::CSR_STEP_PERIOD, step);
      junk = mwto_pkg::CSR_DATA_W'($urandom_range(0, 65535));
      write_reg(mwto_pkg::CSR_VOLUME,
                {junk[mwto_pkg::CSR_DATA_W-1:mwto_pkg::LEVEL_W], vol});
   endtask

   task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
      @(posedge clock);
      send_idle_pct  <= send_pct;
      recv_stall_pct <= recv_pct;
   endtask

   // hold the sender until the block has returned every transfer
   task automatic drain();
      while (pending_ticks.size() > 0 || expected_tones.size() > 0
             || tick_ch.valid || tone_ch.valid)
         @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic send_ticks(input logic seq[$]);
      foreach (seq[i]) pending_ticks.push_back(seq[i]);
      drain();
   endtask

   task automatic send_random(input int unsigned count);
      repeat (count) pending_ticks.push_back($urandom_range(0, 99) < 85);
   endtask

   function automatic logic [mwto_pkg::COUNT_W-1:0] pick_period();
      int unsigned r;
      r = $urandom_range(0, 9);
      case (r)
         6:       return '0;
         7:       return '1;
         8:       return mwto_pkg::COUNT_W'($urandom_range(0, 65535));
         9:       return mwto_pkg::COUNT_W'($urandom_range(8, 40));
         default: return mwto_pkg::COUNT_W'($urandom_range(0, 7));
      endcase
   endfunction

   function automatic logic [mwto_pkg::MODE_W-1:0] pick_mode();
      int unsigned r;
      r = $urandom_range(0, 11);
      if (r >= 8) return mwto_pkg::MODE_W'($urandom_range(0, 7));
      case (r % 4)
         0:       return mwto_pkg::WAVE_SQUARE;
         1:       return mwto_pkg::WAVE_SAW;
         2:       return mwto_pkg::WAVE_TRIANGLE;
         default: return mwto_pkg::WAVE_NOISE;
      endcase
   endfunction

   function automatic logic [mwto_pkg::LEVEL_W-1:0] pick_volume();
      int unsigned r;
      r = $urandom_range(0, 5);
      case (r)
         0:       return '0;
         1:       return '1;
         default: return mwto_pkg::LEVEL_W'($urandom_range(0, 255));
      endcase
   endfunction

   initial begin
      reset           = 1'b1;
      csr_we          = 1'b0;
      csr_index       = '0;
      csr_wdata       = '0;
      tick_ch.valid   = 1'b0;
      tick_ch.advance = 1'b0;
      tone_ch.ready   = 1'b0;
      send_idle_pct   = 0;
      recv_stall_pct  = 0;
      cfg_mode        = mwto_pkg::WAVE_OFF;
      cfg_half        = '0;
      cfg_step        = '0;
      cfg_volume      = mwto_pkg::VOLUME_RESET;
      osc_period      = '0;
      osc_step        = '0;
      osc_level       = '0;
      osc_falling     = 1'b0;
      osc_lfsr        = mwto_pkg::LFSR_SEED;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      send_ticks('{1'b0, 1'b1, 1'b1});
      configure(mwto_pkg::WAVE_SQUARE, '0, '0, '1);
      send_ticks('{1'b1, 1'b1, 1'b0, 1'b1});
      configure(mwto_pkg::WAVE_SAW, '1, '0, 8'h80);
      send_ticks('{1'b1, 1'b1, 1'b1});
      configure(mwto_pkg::WAVE_TRIANGLE, 16'd1, '0, '1);
      send_ticks('{1'b1, 1'b1, 1'b1, 1'b1});
      configure(mwto_pkg::WAVE_NOISE, '0, '0, '0);
      send_ticks('{1'b1, 1'b1});
      write_reg(mwto_pkg::CSR_VOLUME, 16'hFFFF);
      send_ticks('{1'b1, 1'b1});
      write_reg(mwto_pkg::CSR_WAVE_MODE, {13'h1FFF, WAVE_SPARE_LO});
      send_ticks('{1'b1});
      write_reg(mwto_pkg::CSR_WAVE_MODE, {13'h0000, WAVE_SPARE_HI});
      send_ticks('{1'b1, 1'b0});

      // run both counters with restarts disabled, then restart from the count
      configure(mwto_pkg::WAVE_SAW, '1, '1, '1);
      repeat (WRAP_TICKS) pending_ticks.push_back(1'b1);
      drain();
      configure(mwto_pkg::WAVE_SQUARE, 16'd100, 16'd100, 8'h5A);
      send_ticks('{1'b1, 1'b1, 1'b1});

      // long saw ramp through the 8-bit level wrap
      set_idling(7, 7);
      configure(mwto_pkg::WAVE_SAW, '1, '0, '1);
      repeat (300) pending_ticks.push_back(1'b1);
      drain();

      for (int unsigned p = 0; p < RAND_PHASES; p++) begin
         case (p % 4)
            0: set_idling(0, 0);
            1: set_idling(59, 0);
            2: set_idling(0, 59);
            default: set_idling(7, 7);
         endcase
         configure(pick_mode(), pick_period(), pick_period(), pick_volume());
         send_random(PHASE_TICKS / 2);
         drain();
         send_random(PHASE_TICKS - PHASE_TICKS / 2);
         drain();
      end

      drain();
      if (error_count == 0 && expected_tones.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/mwto_pkg.sv
rtl/mwto_req_if.sv
rtl/mwto_rsp_if.sv
rtl/mwto_duty.sv
rtl/multiwave_tone_oscillator_unit.sv
tb/sv/multiwave_tone_oscillator_unit_tb.sv
